>>> rtl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// Line/rectangle clipper package
// Widths, coordinate types, register indexes and the saturation helper shared
// by the clipper, its divider and its checker.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int CW         = 25;          // screen coordinate width
  localparam int RW         = 20;          // layout coordinate width
  localparam int SCW        = 16;          // scale register width
  localparam int OFW        = 12;          // offset register width
  localparam int CFG_DW     = 16;          // configuration data width
  localparam int FRAC       = 8;           // coordinate fraction bits
  localparam int SCALE_FRAC = 8;           // scale fraction bits
  localparam int DW         = CW + 1;      // coordinate difference width
  localparam int PW         = 2 * DW;      // numerator width
  localparam int QW         = DW;          // quotient bits resolved
  localparam int QSW        = QW + 2;      // signed clamped quotient width
  localparam int PRW        = RW + SCW + 1;
  localparam int SW         = 48;          // working width before saturation
  localparam int DIV_LAT    = QW + 3;
  localparam int PIPE_DEPTH = 2 * DIV_LAT + 9;

  localparam logic [SCW-1:0] SCALE_RST  = SCW'(256);
  localparam logic [OFW-1:0] OFFSET_RST = '0;

  localparam longint COORD_MIN = -(longint'(1) << (CW - 1));
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;

  typedef enum logic [0:0] {
    REG_SCALE  = 1'b0,
    REG_OFFSET = 1'b1
  } cfg_reg_e;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [DW-1:0]  diff_t;
  typedef logic signed [PW-1:0]  num_t;
  typedef logic signed [QSW-1:0] quo_t;
  typedef logic signed [SW-1:0]  wide_t;

  // Everything an item carries past a divider.
  typedef struct packed {
    logic   vis;
    coord_t x1;
    coord_t y1;
    diff_t  dx;
    diff_t  dy;
    coord_t xmin;
    coord_t xmax;
    coord_t ymin;
    coord_t ymax;
    coord_t xa;
    coord_t ya;
    coord_t xb;
    coord_t yb;
    logic   ca;
    logic   cb;
  } item_t;

  function automatic coord_t sat_coord(wide_t v);
    coord_t r;
    if (v < wide_t'(COORD_MIN)) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else if (v > wide_t'(COORD_MAX)) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/lrc_div.sv
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division, one quotient bit per stage. The quotient truncates
// toward zero and its magnitude is clamped to 2^QW, which is enough for a
// result that is saturated to the coordinate range afterwards.
// ----------------------------------------------------------------------------
module lrc_div (
  input  logic           clk_i,
  input  lrc_pkg::num_t  num_i,
  input  lrc_pkg::diff_t den_i,
  output lrc_pkg::quo_t  quo_o
);

  localparam int PW = lrc_pkg::PW;
  localparam int DW = lrc_pkg::DW;
  localparam int QW = lrc_pkg::QW;

  logic [PW-1:0] nmag_a_q;
  logic [DW-1:0] dmag_a_q;
  logic          neg_a_q;

  logic [PW-1:0] rem_q  [QW];
  logic [DW-1:0] dmag_q [QW];
  logic [QW-1:0] qb_q   [QW+1];
  logic          neg_q  [QW+1];
  logic          ovf_q  [QW+1];

  lrc_pkg::quo_t quo_q;
  logic [QW:0]   mag;

  always_ff @(posedge clk_i) begin
    nmag_a_q <= num_i[PW-1] ? PW'(-num_i) : PW'(num_i);
    dmag_a_q <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    neg_a_q  <= num_i[PW-1] ^ den_i[DW-1];
  end

  // A quotient of 2^QW or more saturates the result anyway.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= nmag_a_q;
    dmag_q[0] <= dmag_a_q;
    neg_q[0]  <= neg_a_q;
    ovf_q[0]  <= (nmag_a_q >= {dmag_a_q, {QW{1'b0}}});
    qb_q[0]   <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [PW-1:0] shifted;
    logic          ge;
    logic [QW-1:0] qb_d;

    always_comb begin
      shifted = {{(PW-DW){1'b0}}, dmag_q[k]} << (QW - 1 - k);
      ge      = (rem_q[k] >= shifted);
      qb_d    = qb_q[k];
      qb_d[QW-1-k] = ge;
    end

    always_ff @(posedge clk_i) begin
      qb_q[k+1]  <= qb_d;
      neg_q[k+1] <= neg_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end

    if (k < QW - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        rem_q[k+1]  <= ge ? rem_q[k] - shifted : rem_q[k];
        dmag_q[k+1] <= dmag_q[k];
      end
    end
  end

  assign mag = ovf_q[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, qb_q[QW]};

  always_ff @(posedge clk_i) begin
    quo_q <= neg_q[QW] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign quo_o = quo_q;

endmodule

>>> rtl/line_rect_clipper_unit.sv
// ----------------------------------------------------------------------------
// Line/rectangle clipper
// Maps a layout rectangle to the screen, rejects a segment lying beyond one
// side and clamps both endpoints, first in x and then in y.
// ----------------------------------------------------------------------------
// The unit takes one item in every clock cycle and never raises busy_o. Each
// item comes out on done_o in the order it was taken. The path runs through
// two pipelined restoring dividers in series, the x clamp and then the y
// clamp, each resolving one quotient bit per stage; both endpoints use their
// own divider pair in parallel. Results cannot be held off, so they must be
// captured in the cycle done_o is high.
module line_rect_clipper_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [lrc_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [lrc_pkg::RW-1:0] rect_ax_i,
  input  logic signed [lrc_pkg::RW-1:0] rect_ay_i,
  input  logic signed [lrc_pkg::RW-1:0] rect_bx_i,
  input  logic signed [lrc_pkg::RW-1:0] rect_by_i,
  input  logic signed [lrc_pkg::CW-1:0] line_ax_i,
  input  logic signed [lrc_pkg::CW-1:0] line_ay_i,
  input  logic signed [lrc_pkg::CW-1:0] line_bx_i,
  input  logic signed [lrc_pkg::CW-1:0] line_by_i,
  output logic                          done_o,
  output logic signed [lrc_pkg::CW-1:0] clip_ax_o,
  output logic signed [lrc_pkg::CW-1:0] clip_ay_o,
  output logic signed [lrc_pkg::CW-1:0] clip_bx_o,
  output logic signed [lrc_pkg::CW-1:0] clip_by_o,
  output logic                          visible_o
);

  localparam int DEPTH = lrc_pkg::PIPE_DEPTH;
  localparam int LAT   = lrc_pkg::DIV_LAT;
  localparam int SHL   = (lrc_pkg::FRAC >= lrc_pkg::SCALE_FRAC) ?
                         lrc_pkg::FRAC - lrc_pkg::SCALE_FRAC : 0;
  localparam int SHR   = (lrc_pkg::FRAC < lrc_pkg::SCALE_FRAC) ?
                         lrc_pkg::SCALE_FRAC - lrc_pkg::FRAC : 0;

  logic [lrc_pkg::SCW-1:0] scale_q;
  logic [lrc_pkg::OFW-1:0] offset_q;
  logic                    accept;
  logic [DEPTH-1:0]        vld_q;

  // Stage 1: scale products.
  logic signed [lrc_pkg::PRW-1:0] pax_q, pay_q, pbx_q, pby_q;
  lrc_pkg::coord_t x1_1_q, y1_1_q, x2_1_q, y2_1_q;
  // Stage 2: mapped corners.
  lrc_pkg::coord_t max_q, may_q, mbx_q, mby_q;
  lrc_pkg::coord_t x1_2_q, y1_2_q, x2_2_q, y2_2_q;
  // Stage 3: box and deltas.
  lrc_pkg::item_t  it3_q;
  // Stages 4 and 5: visibility, x clamp and its numerators.
  lrc_pkg::item_t  it4_d, it4_q, it5_q;
  lrc_pkg::diff_t  lda_d, ldb_d, lda_q, ldb_q;
  lrc_pkg::num_t   numxa_q, numxb_q;
  lrc_pkg::item_t  dlx_q [LAT];
  lrc_pkg::quo_t   qxa, qxb;
  // Stages 6 to 8: y recompute, y clamp and its numerators.
  lrc_pkg::item_t  it6_d, it6_q, it7_d, it7_q, it8_q;
  lrc_pkg::diff_t  lya_d, lyb_d, lya_q, lyb_q;
  lrc_pkg::num_t   numya_q, numyb_q;
  lrc_pkg::item_t  dly_q [LAT];
  lrc_pkg::quo_t   qya, qyb;
  lrc_pkg::item_t  itf;
  // Stage 9: results.
  lrc_pkg::coord_t cax_d, cbx_d;
  lrc_pkg::coord_t cax_q, cay_q, cbx_q, cby_q;
  logic            vis_q;

  function automatic lrc_pkg::coord_t map_coord(logic signed [lrc_pkg::PRW-1:0] p,
                                                logic [lrc_pkg::OFW-1:0] ofs);
    lrc_pkg::wide_t w;
    lrc_pkg::wide_t rnd;
    lrc_pkg::wide_t s;
    w   = lrc_pkg::wide_t'(p);
    rnd = w[lrc_pkg::SW-1] ? lrc_pkg::wide_t'((longint'(1) << SHR) - 1) : '0;
    s   = ((w + rnd) >>> SHR) <<< SHL;
    s   = s + (lrc_pkg::wide_t'(ofs) <<< lrc_pkg::FRAC);
    return lrc_pkg::sat_coord(s);
  endfunction

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= lrc_pkg::SCALE_RST;
      offset_q <= lrc_pkg::OFFSET_RST;
    end else if (cfg_we_i) begin
      case (lrc_pkg::cfg_reg_e'(cfg_idx_i))
        lrc_pkg::REG_SCALE:  scale_q  <= cfg_data_i[lrc_pkg::SCW-1:0];
        lrc_pkg::REG_OFFSET: offset_q <= cfg_data_i[lrc_pkg::OFW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DEPTH-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    pax_q  <= rect_ax_i * $signed({1'b0, scale_q});
    pay_q  <= rect_ay_i * $signed({1'b0, scale_q});
    pbx_q  <= rect_bx_i * $signed({1'b0, scale_q});
    pby_q  <= rect_by_i * $signed({1'b0, scale_q});
    x1_1_q <= line_ax_i;
    y1_1_q <= line_ay_i;
    x2_1_q <= line_bx_i;
    y2_1_q <= line_by_i;

    max_q  <= map_coord(pax_q, offset_q);
    may_q  <= map_coord(pay_q, offset_q);
    mbx_q  <= map_coord(pbx_q, offset_q);
    mby_q  <= map_coord(pby_q, offset_q);
    x1_2_q <= x1_1_q;
    y1_2_q <= y1_1_q;
    x2_2_q <= x2_1_q;
    y2_2_q <= y2_1_q;
  end

  always_ff @(posedge clk_i) begin
    it3_q.xmin <= (max_q < mbx_q) ? max_q : mbx_q;
    it3_q.xmax <= (max_q < mbx_q) ? mbx_q : max_q;
    it3_q.ymin <= (may_q < mby_q) ? may_q : mby_q;
    it3_q.ymax <= (may_q < mby_q) ? mby_q : may_q;
    it3_q.x1   <= x1_2_q;
    it3_q.y1   <= y1_2_q;
    it3_q.xa   <= x1_2_q;
    it3_q.ya   <= y1_2_q;
    it3_q.xb   <= x2_2_q;
    it3_q.yb   <= y2_2_q;
    it3_q.dx   <= lrc_pkg::diff_t'(x2_2_q) - lrc_pkg::diff_t'(x1_2_q);
    it3_q.dy   <= lrc_pkg::diff_t'(y2_2_q) - lrc_pkg::diff_t'(y1_2_q);
    it3_q.ca   <= 1'b0;
    it3_q.cb   <= 1'b0;
    it3_q.vis  <= 1'b1;
  end

  // Visibility is folded in here, where the box is already registered.
  always_comb begin
    logic xlo_a, xhi_a, xlo_b, xhi_b;
    lrc_pkg::coord_t lim_a, lim_b;
    it4_d     = it3_q;
    it4_d.vis = !(it3_q.xa < it3_q.xmin && it3_q.xb < it3_q.xmin) &&
                !(it3_q.xa > it3_q.xmax && it3_q.xb > it3_q.xmax) &&
                !(it3_q.ya < it3_q.ymin && it3_q.yb < it3_q.ymin) &&
                !(it3_q.ya > it3_q.ymax && it3_q.yb > it3_q.ymax);
    xlo_a = it3_q.xa < it3_q.xmin;
    xhi_a = it3_q.xa > it3_q.xmax;
    xlo_b = it3_q.xb < it3_q.xmin;
    xhi_b = it3_q.xb > it3_q.xmax;
    lim_a = xlo_a ? it3_q.xmin : it3_q.xmax;
    lim_b = xlo_b ? it3_q.xmin : it3_q.xmax;
    it4_d.ca = xlo_a || xhi_a;
    it4_d.cb = xlo_b || xhi_b;
    if (it4_d.ca) begin
      it4_d.xa = lim_a;
    end
    if (it4_d.cb) begin
      it4_d.xb = lim_b;
    end
    lda_d = lrc_pkg::diff_t'(lim_a) - lrc_pkg::diff_t'(it3_q.x1);
    ldb_d = lrc_pkg::diff_t'(lim_b) - lrc_pkg::diff_t'(it3_q.x1);
  end

  always_ff @(posedge clk_i) begin
    it4_q   <= it4_d;
    lda_q   <= lda_d;
    ldb_q   <= ldb_d;
    it5_q   <= it4_q;
    numxa_q <= it4_q.dy * lda_q;
    numxb_q <= it4_q.dy * ldb_q;
  end

  lrc_div u_div_xa (.clk_i(clk_i), .num_i(numxa_q), .den_i(it5_q.dx), .quo_o(qxa));
  lrc_div u_div_xb (.clk_i(clk_i), .num_i(numxb_q), .den_i(it5_q.dx), .quo_o(qxb));

  always_ff @(posedge clk_i) begin
    dlx_q[0] <= it5_q;
    for (int i = 1; i < LAT; i++) begin
      dlx_q[i] <= dlx_q[i-1];
    end
  end

  // y along the segment; a zero run in x keeps the current y.
  always_comb begin
    it6_d = dlx_q[LAT-1];
    if (it6_d.ca && it6_d.dx != '0) begin
      it6_d.ya = lrc_pkg::sat_coord(lrc_pkg::wide_t'(it6_d.y1) + lrc_pkg::wide_t'(qxa));
    end
    if (it6_d.cb && it6_d.dx != '0) begin
      it6_d.yb = lrc_pkg::sat_coord(lrc_pkg::wide_t'(it6_d.y1) + lrc_pkg::wide_t'(qxb));
    end
  end

  always_comb begin
    logic ylo_a, yhi_a, ylo_b, yhi_b;
    lrc_pkg::coord_t lim_a, lim_b;
    it7_d = it6_q;
    ylo_a = it6_q.ya < it6_q.ymin;
    yhi_a = it6_q.ya > it6_q.ymax;
    ylo_b = it6_q.yb < it6_q.ymin;
    yhi_b = it6_q.yb > it6_q.ymax;
    lim_a = ylo_a ? it6_q.ymin : it6_q.ymax;
    lim_b = ylo_b ? it6_q.ymin : it6_q.ymax;
    it7_d.ca = ylo_a || yhi_a;
    it7_d.cb = ylo_b || yhi_b;
    if (it7_d.ca) begin
      it7_d.ya = lim_a;
    end
    if (it7_d.cb) begin
      it7_d.yb = lim_b;
    end
    lya_d = lrc_pkg::diff_t'(lim_a) - lrc_pkg::diff_t'(it6_q.y1);
    lyb_d = lrc_pkg::diff_t'(lim_b) - lrc_pkg::diff_t'(it6_q.y1);
  end

  always_ff @(posedge clk_i) begin
    it6_q   <= it6_d;
    it7_q   <= it7_d;
    lya_q   <= lya_d;
    lyb_q   <= lyb_d;
    it8_q   <= it7_q;
    numya_q <= it7_q.dx * lya_q;
    numyb_q <= it7_q.dx * lyb_q;
  end

  lrc_div u_div_ya (.clk_i(clk_i), .num_i(numya_q), .den_i(it8_q.dy), .quo_o(qya));
  lrc_div u_div_yb (.clk_i(clk_i), .num_i(numyb_q), .den_i(it8_q.dy), .quo_o(qyb));

  always_ff @(posedge clk_i) begin
    dly_q[0] <= it8_q;
    for (int i = 1; i < LAT; i++) begin
      dly_q[i] <= dly_q[i-1];
    end
  end

  assign itf = dly_q[LAT-1];

  always_comb begin
    cax_d = itf.xa;
    cbx_d = itf.xb;
    if (itf.ca && itf.dy != '0) begin
      cax_d = lrc_pkg::sat_coord(lrc_pkg::wide_t'(itf.x1) + lrc_pkg::wide_t'(qya));
    end
    if (itf.cb && itf.dy != '0) begin
      cbx_d = lrc_pkg::sat_coord(lrc_pkg::wide_t'(itf.x1) + lrc_pkg::wide_t'(qyb));
    end
  end

  always_ff @(posedge clk_i) begin
    vis_q <= itf.vis;
    cax_q <= itf.vis ? cax_d  : '0;
    cay_q <= itf.vis ? itf.ya : '0;
    cbx_q <= itf.vis ? cbx_d  : '0;
    cby_q <= itf.vis ? itf.yb : '0;
  end

  assign done_o    = vld_q[DEPTH-1];
  assign clip_ax_o = cax_q;
  assign clip_ay_o = cay_q;
  assign clip_bx_o = cbx_q;
  assign clip_by_o = cby_q;
  assign visible_o = vis_q;

endmodule

>>> rtl/lrc_checker.sv
// ----------------------------------------------------------------------------
// Line/rectangle clipper checker
// Port-level checks on item flow and rejected results, bound to the top.
// ----------------------------------------------------------------------------
module lrc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic signed [lrc_pkg::CW-1:0] clip_ax_o,
  input logic signed [lrc_pkg::CW-1:0] clip_ay_o,
  input logic signed [lrc_pkg::CW-1:0] clip_bx_o,
  input logic signed [lrc_pkg::CW-1:0] clip_by_o,
  input logic                          visible_o
);

  localparam int DEPTH = lrc_pkg::PIPE_DEPTH;

  // Cycles since reset release, saturating at the pipeline depth.
  logic [$clog2(DEPTH+1)-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cnt_q != ($clog2(DEPTH+1))'(DEPTH)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("unit raised busy");

  a_fill_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != ($clog2(DEPTH+1))'(DEPTH)) |-> !done_o)
    else $error("result before any item could arrive");

  a_one_for_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == ($clog2(DEPTH+1))'(DEPTH)) |-> (done_o == $past(start_i && !busy_o, DEPTH)))
    else $error("result does not match an item taken earlier");

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !visible_o) |->
      (clip_ax_o == '0 && clip_ay_o == '0 && clip_bx_o == '0 && clip_by_o == '0))
    else $error("rejected item has nonzero coordinates");

endmodule

bind line_rect_clipper_unit lrc_checker u_lrc_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line/rectangle clipper testbench
// Drives rectangles and segments through the command port under random
// sender gaps, predicts each clipped segment in the bench and compares every
// result in order against the prediction, across several scale/offset settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 100;

  typedef struct packed {
    logic signed [lrc_pkg::RW-1:0] rax, ray, rbx, rby;
    lrc_pkg::coord_t lax, lay, lbx, lby;
  } seg_t;

  typedef struct packed {
    lrc_pkg::coord_t ax, ay, bx, by;
    logic   vis;
  } clip_t;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0, cfg_idx_i = 0;
  logic [lrc_pkg::CFG_DW-1:0] cfg_data_i = '0;
  logic start_i = 0, busy_o, done_o, visible_o;
  logic signed [lrc_pkg::RW-1:0] rect_ax_i = '0, rect_ay_i = '0;
  logic signed [lrc_pkg::RW-1:0] rect_bx_i = '0, rect_by_i = '0;
  lrc_pkg::coord_t line_ax_i = '0, line_ay_i = '0, line_bx_i = '0, line_by_i = '0;
  lrc_pkg::coord_t clip_ax_o, clip_ay_o, clip_bx_o, clip_by_o;

  line_rect_clipper_unit DUT (.*);

  seg_t  pending_q[$];
  clip_t expected_q[$];
  longint cur_scale = 256, cur_offset = 0;
  int    idle_pct = 0;
  int    mismatches = 0;
  int    quiet_cycles = 0;
  bit    driving = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic longint clamp24(longint v);
    if (v < lrc_pkg::COORD_MIN) return lrc_pkg::COORD_MIN;
    if (v > lrc_pkg::COORD_MAX) return lrc_pkg::COORD_MAX;
    return v;
  endfunction

  // Screen position of a layout coordinate; fraction bits match the scale.
  function automatic longint to_screen(longint c);
    return clamp24(c * cur_scale + (cur_offset <<< lrc_pkg::FRAC));
  endfunction

  function automatic longint interp(longint cur, longint a1, longint da, longint lim,
                                    longint b1, longint db);
    if (db == 0) return cur;
    return clamp24(a1 + (da * (lim - b1)) / db);
  endfunction

  function automatic clip_t clip_segment(seg_t s);
    clip_t r;
    longint ax, ay, bx, by, x1, y1, x2, y2, xmin, xmax, ymin, ymax, dx, dy;
    longint px[2], py[2];
    bit vis;
    ax = to_screen(s.rax); ay = to_screen(s.ray);
    bx = to_screen(s.rbx); by = to_screen(s.rby);
    x1 = s.lax; y1 = s.lay; x2 = s.lbx; y2 = s.lby;
    xmin = ax < bx ? ax : bx; xmax = ax < bx ? bx : ax;
    ymin = ay < by ? ay : by; ymax = ay < by ? by : ay;
    dx = x2 - x1; dy = y2 - y1;
    px[0] = 0; py[0] = 0; px[1] = 0; py[1] = 0;
    vis = !(x1 < xmin && x2 < xmin) && !(x1 > xmax && x2 > xmax) &&
          !(y1 < ymin && y2 < ymin) && !(y1 > ymax && y2 > ymax);
    if (vis) begin
      px[0] = x1; py[0] = y1; px[1] = x2; py[1] = y2;
      for (int j = 0; j < 2; j++) begin
        // The slope always comes from the unclipped endpoints.
        if (px[j] < xmin) begin
          px[j] = xmin; py[j] = interp(py[j], y1, dy, xmin, x1, dx);
        end else if (px[j] > xmax) begin
          px[j] = xmax; py[j] = interp(py[j], y1, dy, xmax, x1, dx);
        end
        if (py[j] < ymin) begin
          py[j] = ymin; px[j] = interp(px[j], x1, dx, ymin, y1, dy);
        end else if (py[j] > ymax) begin
          py[j] = ymax; px[j] = interp(px[j], x1, dx, ymax, y1, dy);
        end
      end
    end
    r.ax = lrc_pkg::coord_t'(px[0]); r.ay = lrc_pkg::coord_t'(py[0]);
    r.bx = lrc_pkg::coord_t'(px[1]); r.by = lrc_pkg::coord_t'(py[1]);
    r.vis = vis;
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (driving && pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
      seg_t s;
      s = pending_q[0];
      start_i <= 1'b1;
      {rect_ax_i, rect_ay_i, rect_bx_i, rect_by_i} <= {s.rax, s.ray, s.rbx, s.rby};
      {line_ax_i, line_ay_i, line_bx_i, line_by_i} <= {s.lax, s.lay, s.lbx, s.lby};
    end else begin
      start_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    bit seen;
    seen = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        seg_t s;
        s = pending_q.pop_front();
        expected_q.push_back(clip_segment(s));
        seen = 1'b1;
      end
      if (done_o) begin
        clip_t got, want;
        seen = 1'b1;
        got = '{clip_ax_o, clip_ay_o, clip_bx_o, clip_by_o, visible_o};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      quiet_cycles <= seen ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic write_reg(lrc_pkg::cfg_reg_e idx, longint val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= lrc_pkg::CFG_DW'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lrc_pkg::REG_SCALE) cur_scale = val; else cur_offset = val;
  endtask

  function automatic logic signed [lrc_pkg::RW-1:0] rand_layout(int span);
    if (span == 0) return lrc_pkg::RW'($urandom);
    return lrc_pkg::RW'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic lrc_pkg::coord_t rand_screen(longint span);
    if (span == 0) return lrc_pkg::coord_t'($urandom);
    return lrc_pkg::coord_t'(longint'($urandom_range(2 * span)) - span);
  endfunction

  // A layout span that keeps the mapped rectangle mostly on screen.
  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      seg_t s;
      int rs, lspan;
      rs = ($urandom_range(9) == 0) ? 0 : int'(longint'(1 << 24) / (cur_scale + 1));
      if (rs > 524287) rs = 524287;
      s.rax = rand_layout(rs); s.ray = rand_layout(rs);
      s.rbx = rand_layout(rs); s.rby = rand_layout(rs);
      lspan = ($urandom_range(9) == 0) ? 0 : 1 << $urandom_range(24, 8);
      s.lax = rand_screen(lspan); s.lay = rand_screen(lspan);
      s.lbx = rand_screen(lspan); s.lby = rand_screen(lspan);
      // Sometimes make a vertical or horizontal segment.
      if ($urandom_range(9) == 0) s.lbx = s.lax;
      if ($urandom_range(9) == 0) s.lby = s.lay;
      pending_q.push_back(s);
    end
  endtask

  task automatic run_phase(int pct);
    idle_pct = pct;
    driving = 1;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    driving = 0;
    wait (expected_q.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  initial begin
    seg_t d;
    int idle_mix[4];
    longint scales[4];
    longint offsets[4];
    idle_mix = '{0, 77, 31, 77};
    scales = '{26, 65535, 0, 700};
    offsets = '{4095, 0, 1234, 4095};
    repeat (6) @(negedge clk_i);
    rst_ni = 1;
    // Directed: extremes, rejection on each side, degenerate segments.
    d = '{-20'sd100, -20'sd100, 20'sd100, 20'sd100, -25'sd1000, 0, 25'sd1000, 0};
    pending_q.push_back(d);
    d = '{-20'sd100, -20'sd100, 20'sd100, 20'sd100, -25'sd90000, 0, -25'sd80000, 25'sd50};
    pending_q.push_back(d);
    d = '{-20'sd100, -20'sd100, 20'sd100, 20'sd100, 25'sd90000, 0, 25'sd80000, 25'sd50};
    pending_q.push_back(d);
    d = '{-20'sd100, -20'sd100, 20'sd100, 20'sd100, 0, -25'sd90000, 25'sd5, -25'sd80000};
    pending_q.push_back(d);
    d = '{-20'sd100, -20'sd100, 20'sd100, 20'sd100, 0, 25'sd90000, 25'sd5, 25'sd80000};
    pending_q.push_back(d);
    d = '{20'sd100, 20'sd100, -20'sd100, -20'sd100, 25'sd5, -25'sd90000, 25'sd5, 25'sd90000};
    pending_q.push_back(d);
    d = '{20'sd100, 20'sd100, -20'sd100, -20'sd100, -25'sd90000, 25'sd7, 25'sd90000, 25'sd7};
    pending_q.push_back(d);
    d = '{20'sd0, 20'sd0, 20'sd0, 20'sd0, 0, 0, 0, 0};
    pending_q.push_back(d);
    d = '{-20'sd524288, -20'sd524288, 20'sd524287, 20'sd524287,
          -25'sd16777216, -25'sd16777216, 25'sd16777215, 25'sd16777215};
    pending_q.push_back(d);
    d = '{-20'sd524288, 20'sd524287, 20'sd524287, -20'sd524288,
          25'sd16777215, -25'sd16777216, -25'sd16777216, 25'sd16777215};
    pending_q.push_back(d);
    d = '{-20'sd10, -20'sd10, 20'sd10, 20'sd10,
          -25'sd16777216, 25'sd16777215, 25'sd16777215, -25'sd16777216};
    pending_q.push_back(d);
    d = '{-20'sd10, -20'sd10, 20'sd10, 20'sd10,
          -25'sd16777216, -25'sd16777216, 25'sd16777215, 25'sd1};
    pending_q.push_back(d);
    add_random(60);
    run_phase(0);
    for (int p = 0; p < 4; p++) begin
      write_reg(lrc_pkg::REG_SCALE, scales[p]);
      write_reg(lrc_pkg::REG_OFFSET, offsets[p]);
      add_random(85);
      run_phase(idle_mix[p]);
      write_reg(lrc_pkg::REG_SCALE, 256 + $urandom_range(2000));
      write_reg(lrc_pkg::REG_OFFSET, $urandom_range(4095));
      add_random(85);
      run_phase(idle_mix[(p + 1) % 4]);
    end
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
